>>> src/qwsin_pkg.sv
// Shared types and constants for the quarter-wave sine table DAC core.
// Used by the fill sequencer and the top level.
// No dependencies.
package qwsin_pkg;

   // Fixed-point series arithmetic widths (Q2.30)
   localparam int TERM_W = 31;        // one series term, x itself included
   localparam int X2_W = 32;          // x * x / 2^30
   localparam int PROD_W = 63;        // TERM_W * X2_W
   localparam int DIVD_W = 33;        // product shifted down by 30
   localparam int DIVR_W = 7;         // largest divisor is 72
   localparam int RECIP_W = 31;       // 2^DIVD_W / 6 is the largest reciprocal
   localparam int SUM_W = 34;         // signed series sum
   localparam int Q_SHIFT = 30;

   localparam int SAMPLE_W = 12;
   localparam int RSP_DATA_W = 16;    // sample padded to whole bytes

   localparam logic [TERM_W-1:0] PIH_Q30 = 31'd1686629713;   // pi/2 in Q2.30
   localparam logic [SAMPLE_W-1:0] CODE_MID = 12'h7FF;
   localparam logic [SAMPLE_W-1:0] CODE_MIRROR = 12'hFFD;
   localparam logic [SAMPLE_W-1:0] CODE_MAX = 12'hFFF;
   localparam int CODE_SHIFT = 19;                           // Q2.30 to 0x800 per unit

   localparam logic [1:0] LAST_TERM = 2'd3;                   // four terms after x

   typedef enum logic [3:0] {
      FS_SERIES_START,
      FS_SQUARE,
      FS_MULT,
      FS_DIV_START,
      FS_DIV_WAIT,
      FS_SERIES_WRITE,
      FS_MIRROR_READ,
      FS_MIRROR_WRITE,
      FS_DONE
   } fill_state_type;

   // Divisor (k+2)(k+1) for the term after term number cnt
   function automatic logic [DIVR_W-1:0] series_divisor(input logic [1:0] cnt);
      logic [DIVR_W-1:0] d;
      unique case (cnt)
         2'd0: d = 7'd6;
         2'd1: d = 7'd20;
         2'd2: d = 7'd42;
         2'd3: d = 7'd72;
         default: d = 7'd6;
      endcase
      return d;
   endfunction

   // floor(2^DIVD_W / divisor) for the same divisors
   function automatic logic [RECIP_W-1:0] series_recip(input logic [1:0] cnt);
      logic [RECIP_W-1:0] r;
      unique case (cnt)
         2'd0: r = RECIP_W'((64'd1 << DIVD_W) / 64'd6);
         2'd1: r = RECIP_W'((64'd1 << DIVD_W) / 64'd20);
         2'd2: r = RECIP_W'((64'd1 << DIVD_W) / 64'd42);
         2'd3: r = RECIP_W'((64'd1 << DIVD_W) / 64'd72);
         default: r = RECIP_W'((64'd1 << DIVD_W) / 64'd6);
      endcase
      return r;
   endfunction

endpackage

>>> src/qwsin_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module qwsin_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/qwsin_div.sv
// Divider for a known divisor by reciprocal multiplication: estimate, then
// one correction step; done rises with the registered quotient. Depends on its parameters.
module qwsin_div #(
   parameter int DW = 33,
   parameter int VW = 7,
   parameter int RCW = 31
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DW-1:0]  dividend,
   input  logic [VW-1:0]  divisor,
   input  logic [RCW-1:0] recip,      // floor(2^DW / divisor)
   output logic           done,
   output logic [DW-1:0]  quotient
);

   localparam int EW = DW + RCW;
   localparam int QW = RCW + VW;

   logic [3:0]     stage_ff, stage_in;
   logic [DW-1:0]  num_ff, num_in;
   logic [VW-1:0]  dvs_ff, dvs_in;
   logic [RCW-1:0] rcp_ff, rcp_in;
   logic [EW-1:0]  est_ff, est_in;
   logic [RCW-1:0] q0_ff, q0_in;
   logic [DW-1:0]  quo_ff, quo_in;
   logic [QW-1:0]  q0_times_d;
   logic [QW-1:0]  rem;
   logic           bump;

   always_comb begin
      stage_in = {stage_ff[2:0], start};
      num_in = num_ff;
      dvs_in = dvs_ff;
      rcp_in = rcp_ff;
      if (start) begin
         num_in = dividend;
         dvs_in = divisor;
         rcp_in = recip;
      end
      // dividend < 2^DW keeps the estimate at most one below the quotient
      est_in = EW'(num_ff) * EW'(rcp_ff);
      q0_in = est_ff[EW-1:DW];
      q0_times_d = QW'(q0_ff) * QW'(dvs_ff);
      rem = QW'(num_ff) - q0_times_d;
      bump = rem >= QW'(dvs_ff);
      quo_in = DW'(q0_ff) + DW'(bump);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
      num_ff <= num_in;
      dvs_ff <= dvs_in;
      rcp_ff <= rcp_in;
      est_ff <= est_in;
      q0_ff <= q0_in;
      quo_ff <= quo_in;
   end

   assign done = stage_ff[3];
   assign quotient = quo_ff;

endmodule

>>> src/qwsin_fill.sv
// Table fill sequencer: Taylor series for the first quarter, mirror passes
// for the rest, all through the table RAM. Depends on qwsin_pkg, qwsin_div.
module qwsin_fill
   import qwsin_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [SAMPLE_W-1:0]              rd_data,
   output logic                             rd_en,
   output logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   output logic                             wr_en,
   output logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   output logic [SAMPLE_W-1:0]              wr_data,
   output logic                             fill_done
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int RW = AW + 1;
   localparam int QUARTER = TABLE_ENTRIES / 4;
   localparam int HALF = TABLE_ENTRIES / 2;
   localparam logic [63:0] X_STEP = 64'(PIH_Q30) << 2;
   localparam logic [63:0] X_QUO = X_STEP / TABLE_ENTRIES;
   localparam logic [63:0] X_REM = X_STEP % TABLE_ENTRIES;

   fill_state_type state_ff, state_in;

   logic [AW-1:0]       idx_ff, idx_in;
   logic [TERM_W-1:0]   x_ff, x_in;
   logic [RW-1:0]       xr_ff, xr_in;
   logic [TERM_W-1:0]   term_ff, term_in;
   logic [X2_W-1:0]     x2_ff, x2_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [1:0]          cnt_ff, cnt_in;

   logic                div_start, div_done;
   logic [DIVD_W-1:0]   div_quotient;
   logic [TERM_W-1:0]   mul_a;
   logic [X2_W-1:0]     mul_b;
   logic [RW-1:0]       xr_sum;
   logic                next_in_series;
   logic                last_entry;
   logic signed [SUM_W-1:0] term_s;
   logic [SUM_W-1-CODE_SHIFT:0] sum_top;
   logic [15:0]         code_wide;
   logic [SAMPLE_W-1:0] series_code;
   logic                flip_half;
   logic [SAMPLE_W-1:0] mirror_code;
   logic [AW-1:0]       mirror_addr;

   qwsin_div #(
      .DW(DIVD_W),
      .VW(DIVR_W),
      .RCW(RECIP_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(prod_ff[PROD_W-1:Q_SHIFT]),
      .divisor(series_divisor(cnt_ff)),
      .recip(series_recip(cnt_ff)),
      .done(div_done),
      .quotient(div_quotient)
   );

   // Shared multiplier: x*x first, then term*x2 for each further term
   assign mul_a = (state_ff == FS_SERIES_START) ? x_ff : term_ff;
   assign mul_b = (state_ff == FS_SERIES_START) ? {1'b0, x_ff} : x2_ff;

   assign next_in_series = ({1'b0, idx_ff} + 1'b1) <= RW'(QUARTER);
   assign last_entry = idx_ff == AW'(TABLE_ENTRIES - 1);
   assign xr_sum = xr_ff + RW'(X_REM);
   assign term_s = $signed({{(SUM_W - TERM_W){1'b0}}, div_quotient[TERM_W-1:0]});

   // Code from the Q2.30 sum: negative clamps to midscale, top clamps to full scale
   assign sum_top = sum_ff[SUM_W-1] ? '0 : sum_ff[SUM_W-1:CODE_SHIFT];
   assign code_wide = 16'(CODE_MID) + 16'(sum_top);
   assign series_code = (code_wide > 16'(CODE_MAX)) ? CODE_MAX : code_wide[SAMPLE_W-1:0];

   // Second quarter copies the first; the upper half flips it, saturating at zero
   assign flip_half = {1'b0, idx_ff} > RW'(HALF);
   assign mirror_code = !flip_half ? rd_data :
                        (rd_data > CODE_MIRROR) ? '0 : CODE_MIRROR - rd_data;
   assign mirror_addr = flip_half ?
                        AW'(RW'(TABLE_ENTRIES) - {1'b0, idx_ff}) :
                        AW'(RW'(HALF) - {1'b0, idx_ff});

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FS_SERIES_START: state_in = FS_SQUARE;
         FS_SQUARE:       state_in = FS_MULT;
         FS_MULT:         state_in = FS_DIV_START;
         FS_DIV_START:    state_in = FS_DIV_WAIT;
         FS_DIV_WAIT: begin
            if (div_done) begin
               state_in = (cnt_ff == LAST_TERM) ? FS_SERIES_WRITE : FS_MULT;
            end
         end
         FS_SERIES_WRITE: state_in = next_in_series ? FS_SERIES_START : FS_MIRROR_READ;
         FS_MIRROR_READ:  state_in = FS_MIRROR_WRITE;
         FS_MIRROR_WRITE: state_in = last_entry ? FS_DONE : FS_MIRROR_READ;
         FS_DONE:         state_in = FS_DONE;
         default:         state_in = FS_DONE;
      endcase
   end

   // Outputs
   always_comb begin
      rd_en = 1'b0;
      wr_en = 1'b0;
      wr_data = series_code;
      div_start = 1'b0;
      fill_done = 1'b0;
      unique case (state_ff)
         FS_DIV_START:    div_start = 1'b1;
         FS_SERIES_WRITE: wr_en = 1'b1;
         FS_MIRROR_READ:  rd_en = 1'b1;
         FS_MIRROR_WRITE: begin
            wr_en = 1'b1;
            wr_data = mirror_code;
         end
         FS_DONE:         fill_done = 1'b1;
         default: begin
         end
      endcase
   end

   assign rd_addr = mirror_addr;
   assign wr_addr = idx_ff;

   // Datapath registers
   always_comb begin
      idx_in = idx_ff;
      x_in = x_ff;
      xr_in = xr_ff;
      term_in = term_ff;
      x2_in = x2_ff;
      prod_in = prod_ff;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         FS_SERIES_START: begin
            prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
            term_in = x_ff;
            sum_in = $signed({{(SUM_W - TERM_W){1'b0}}, x_ff});
            cnt_in = '0;
         end
         FS_SQUARE: x2_in = prod_ff[Q_SHIFT+X2_W-1:Q_SHIFT];
         FS_MULT:   prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
         FS_DIV_WAIT: begin
            if (div_done) begin
               term_in = div_quotient[TERM_W-1:0];
               // terms alternate: subtract after x, then add, and so on
               sum_in = cnt_ff[0] ? sum_ff + term_s : sum_ff - term_s;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         FS_SERIES_WRITE: begin
            idx_in = idx_ff + 1'b1;
            if (xr_sum >= RW'(TABLE_ENTRIES)) begin
               xr_in = xr_sum - RW'(TABLE_ENTRIES);
               x_in = x_ff + TERM_W'(X_QUO) + 1'b1;
            end else begin
               xr_in = xr_sum;
               x_in = x_ff + TERM_W'(X_QUO);
            end
         end
         FS_MIRROR_WRITE: begin
            if (!last_entry) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_SERIES_START;
         idx_ff <= '0;
         x_ff <= '0;
         xr_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         x_ff <= x_in;
         xr_ff <= xr_in;
      end
      term_ff <= term_in;
      x2_ff <= x2_in;
      prod_ff <= prod_in;
      sum_ff <= sum_in;
      cnt_ff <= cnt_in;
   end

endmodule

>>> src/quarter_wave_sine_table_dac_core.sv
// Sine/cosine lookup core for a 12-bit DAC, top level.
// Depends on qwsin_pkg, qwsin_ram, qwsin_fill (which uses qwsin_div).
//
// After reset the core fills its TABLE_ENTRIES x 12-bit table and holds
// req_tready low until the fill ends. The first quarter plus one entry comes
// from a five-term Taylor series of sine in Q2.30, one shared multiplier and
// a reciprocal-multiply divider; the rest of the table is mirrored from the
// entries already written. Once filled, the core takes one phase per clock
// and returns one sample per clock while rsp_tready stays high; each sample
// passes the registered table read and then the output register. The single
// read port of the table RAM sets that rate. The index is the top bits of
// phase scaled by TABLE_ENTRIES; a cosine request adds a quarter of the
// table, modulo the table size. An output stage behind the RAM lets a new
// request in while a finished sample waits on rsp_tready.
module quarter_wave_sine_table_dac_core
   import qwsin_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256,
   parameter int PHASE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((PHASE_BITS + 7) / 8) * 8-1:0] req_tdata,   // [PHASE_BITS-1:0] phase
   input  logic                                  req_tuser,   // [0] want_cosine
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [RSP_DATA_W-1:0]                 rsp_tdata    // [11:0] sample
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int RW = AW + 1;
   localparam int NW = $clog2(TABLE_ENTRIES + 1);
   localparam int PW = PHASE_BITS + NW;
   localparam int QUARTER = TABLE_ENTRIES / 4;

   logic                fill_done;
   logic                fill_rd_en, fill_wr_en;
   logic [AW-1:0]       fill_rd_addr, fill_wr_addr;
   logic [SAMPLE_W-1:0] fill_wr_data;

   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [SAMPLE_W-1:0] ram_rd_data;

   logic [PHASE_BITS-1:0] req_phase;
   logic [PW-1:0]       phase_scaled;
   logic [AW-1:0]       sin_idx;
   logic [RW-1:0]       cos_sum;
   logic [AW-1:0]       lookup_idx;

   logic                ram_valid_ff, ram_valid_in;
   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                ram_move;
   logic                req_xfer;

   qwsin_fill #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_fill (
      .clock(clock),
      .reset(reset),
      .rd_data(ram_rd_data),
      .rd_en(fill_rd_en),
      .rd_addr(fill_rd_addr),
      .wr_en(fill_wr_en),
      .wr_addr(fill_wr_addr),
      .wr_data(fill_wr_data),
      .fill_done(fill_done)
   );

   qwsin_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock(clock),
      .wr_en(fill_wr_en),
      .wr_addr(fill_wr_addr),
      .wr_data(fill_wr_data),
      .rd_en(ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Table index: top bits of phase * entries, plus a quarter table for cosine
   assign req_phase = req_tdata[PHASE_BITS-1:0];
   assign phase_scaled = PW'(req_phase) * PW'(TABLE_ENTRIES);
   assign sin_idx = AW'(phase_scaled[PW-1:PHASE_BITS]);
   assign cos_sum = {1'b0, sin_idx} + RW'(QUARTER);
   always_comb begin
      if (!req_tuser) begin
         lookup_idx = sin_idx;
      end else if (cos_sum >= RW'(TABLE_ENTRIES)) begin
         lookup_idx = AW'(cos_sum - RW'(TABLE_ENTRIES));
      end else begin
         lookup_idx = cos_sum[AW-1:0];
      end
   end

   // Read data moves to the output register when that register is free or drains
   assign ram_move = ram_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = fill_done && (!ram_valid_ff || ram_move);
   assign req_xfer = req_tvalid && req_tready;

   // The read port belongs to the fill until it ends; a stalled read holds its data
   assign ram_rd_en = fill_done ? req_xfer : fill_rd_en;
   assign ram_rd_addr = fill_done ? lookup_idx : fill_rd_addr;

   always_comb begin
      ram_valid_in = ram_valid_ff;
      if (req_xfer) begin
         ram_valid_in = 1'b1;
      end else if (ram_move) begin
         ram_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      sample_in = sample_ff;
      if (ram_move) begin
         out_valid_in = 1'b1;
         sample_in = ram_rd_data;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ram_valid_ff <= ram_valid_in;
         out_valid_ff <= out_valid_in;
      end
      sample_ff <= sample_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = RSP_DATA_W'(sample_ff);

   // No request is taken before the table is complete
   assert property (@(posedge clock) disable iff (reset) req_tready |-> fill_done)
      else $error("request taken during table fill");

   // Once complete, the table stays complete until reset
   assert property (@(posedge clock) disable iff (reset) fill_done |=> fill_done)
      else $error("fill done dropped");

   // The table is never written while lookups run
   assert property (@(posedge clock) disable iff (reset) fill_wr_en |-> !fill_done)
      else $error("table write after fill");

   // A read result that cannot move on is kept, not dropped
   assert property (@(posedge clock) disable iff (reset)
      (ram_valid_ff && !ram_move) |=> (ram_valid_ff && $stable(ram_rd_data)))
      else $error("pending table read lost");

endmodule

>>> tb/sv/tb_quarter_wave_sine_table_dac_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for quarter_wave_sine_table_dac_core: phase stream in,
// DAC sample stream out, each sample checked against a locally built sine table.
// Depends on qwsin_pkg and the core RTL only.
module tb_quarter_wave_sine_table_dac_core;
   import qwsin_pkg::*;

   localparam int TABLE_ENTRIES = 256;
   localparam int PHASE_BITS = 16;
   localparam int REQ_DATA_W = ((PHASE_BITS + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 1800;
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_PRINTED = 20;

   typedef struct {
      logic [PHASE_BITS-1:0] phase;
      logic                  want_cosine;
      bit                    drain_first;   // wait for every sample before offering
   } phase_req_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;    // [15:0] phase
   logic                  req_tuser = 1'b0;  // [0] want_cosine
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [11:0] sample

   // Expected codes for the whole table, built once at time zero
   logic [SAMPLE_W-1:0] sine_codes [TABLE_ENTRIES];

   phase_req_type       pending_reqs[$];
   phase_req_type       next_req;
   logic [SAMPLE_W-1:0] samples_due[$];

   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   int req_gap = 0;
   int rsp_stall = 0;
   int hold_left = 0;
   int holds_done = 0;
   int reqs_total = 0;
   int reqs_accepted = 0;
   int samples_seen = 0;
   int mismatch_count = 0;

   quarter_wave_sine_table_dac_core #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .PHASE_BITS(PHASE_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // Five-term Taylor sine in Q2.30, mapped to a DAC code around midscale
   function automatic logic [SAMPLE_W-1:0] series_code(int unsigned entry);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          code;
      bit              negate;
      x = (longint'(PIH_Q30) * 4 * entry) / TABLE_ENTRIES;
      x2 = (x * x) >> Q_SHIFT;
      term = x;
      sum = 0;
      negate = 1'b0;
      for (int k = 1; k < 10; k += 2) begin
         sum += negate ? -longint'(term) : longint'(term);
         term = ((term * x2) >> Q_SHIFT) / longint'((k + 2) * (k + 1));
         negate = !negate;
      end
      if (sum < 0)
         sum = 0;
      code = longint'(CODE_MID) + (sum >>> CODE_SHIFT);
      if (code > longint'(CODE_MAX))
         code = longint'(CODE_MAX);
      return code[SAMPLE_W-1:0];
   endfunction

   // Quarter from the series, second quarter mirrored, upper half flipped with
   // saturation at zero (the peak code sits above the flip constant)
   function automatic void build_sine_table();
      logic [SAMPLE_W-1:0] mirrored;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (i <= TABLE_ENTRIES / 4) begin
            sine_codes[i] = series_code(i);
         end else if (i > TABLE_ENTRIES / 2) begin
            mirrored = sine_codes[TABLE_ENTRIES - i];
            sine_codes[i] = (mirrored > CODE_MIRROR) ? '0 : CODE_MIRROR - mirrored;
         end else begin
            sine_codes[i] = sine_codes[TABLE_ENTRIES / 2 - i];
         end
      end
   endfunction

   function automatic logic [SAMPLE_W-1:0] lookup_sample(logic [PHASE_BITS-1:0] phase,
                                                         logic want_cosine);
      longint unsigned slot;
      slot = (longint'(phase) * TABLE_ENTRIES) >> PHASE_BITS;
      if (want_cosine)
         slot += TABLE_ENTRIES / 4;
      slot = slot % TABLE_ENTRIES;
      return sine_codes[slot];
   endfunction

   // Alternate calm stretches (no idling) with busy ones (randomly drawn idle gaps)
   function automatic int draw_idle(int count, int offset);
      if (((count + offset) / 150) % 3 == 0)
         return 0;
      return $urandom_range(0, 6);
   endfunction

   task automatic report_mismatch(string what, logic [SAMPLE_W-1:0] got,
                                  logic [SAMPLE_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("MISMATCH %s: got 0x%03h, expected 0x%03h at %0t ns",
                  what, got, want, $time);
   endtask

   task automatic queue_req(logic [PHASE_BITS-1:0] phase, logic want_cosine,
                            bit drain_first);
      phase_req_type item;
      item.phase = phase;
      item.want_cosine = want_cosine;
      item.drain_first = drain_first;
      pending_reqs.push_back(item);
      reqs_total++;
   endtask

   // Monitor: record transfers on both channels and check samples in order.
   // Check the result side before recording a new request so a stray sample
   // never matches an expectation pushed in the same cycle.
   always @(posedge clock) begin
      req_taken = !reset && req_tvalid && req_tready;
      rsp_taken = !reset && rsp_tvalid && rsp_tready;
      if (rsp_taken) begin
         if (samples_due.size() == 0) begin
            report_mismatch("unexpected sample", rsp_tdata[SAMPLE_W-1:0], '0);
         end else if (rsp_tdata[SAMPLE_W-1:0] !== samples_due[0]) begin
            report_mismatch("sample", rsp_tdata[SAMPLE_W-1:0], samples_due.pop_front());
         end else begin
            void'(samples_due.pop_front());
         end
         samples_seen++;
         rsp_stall = draw_idle(samples_seen, 75);
      end
      if (req_taken) begin
         samples_due.push_back(lookup_sample(req_tdata[PHASE_BITS-1:0], req_tuser));
         reqs_accepted++;
      end
   end

   // Long receiver hold-off: twice in the run, stop taking samples for a long
   // stretch while the sender keeps offering, so the core backs up and stalls
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
      end else if (holds_done < 2 && samples_seen >= 400 + 900 * holds_done) begin
         hold_left = LONG_HOLD_CYCLES;
         holds_done++;
      end
   end

   // Driver: hold each item until its transfer, then idle for the drawn gap
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the offered item
      end else if (req_gap > 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].drain_first && samples_due.size() != 0)) begin
         req_tvalid <= 1'b0;
      end else begin
         next_req = pending_reqs.pop_front();
         req_tvalid <= 1'b1;
         req_tdata <= REQ_DATA_W'(next_req.phase);
         req_tuser <= next_req.want_cosine;
         req_gap = draw_idle(reqs_accepted, 0);
      end
   end

   // Receiver: drop ready for the drawn stall after each sample, or while held
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      logic [PHASE_BITS-1:0] phase;
      build_sine_table();

      // Directed: ends of the range, quadrant edges, peak and trough, cosine wrap
      queue_req(16'h0000, 1'b0, 1'b0);
      queue_req(16'hFFFF, 1'b0, 1'b0);
      queue_req(16'h00FF, 1'b0, 1'b0);
      queue_req(16'h0100, 1'b0, 1'b0);
      queue_req(16'h3FFF, 1'b0, 1'b0);
      queue_req(16'h4000, 1'b0, 1'b0);   // peak code
      queue_req(16'h40FF, 1'b0, 1'b0);
      queue_req(16'h7FFF, 1'b0, 1'b0);
      queue_req(16'h8000, 1'b0, 1'b0);
      queue_req(16'h8100, 1'b0, 1'b0);   // first flipped entry
      queue_req(16'hC000, 1'b0, 1'b0);   // flip of the peak saturates at zero
      queue_req(16'hBFFF, 1'b0, 1'b0);
      queue_req(16'h0000, 1'b1, 1'b0);
      queue_req(16'hFFFF, 1'b1, 1'b0);   // cosine index wraps
      queue_req(16'hC000, 1'b1, 1'b0);   // cosine wraps to entry zero
      queue_req(16'h8000, 1'b1, 1'b0);   // cosine lands on the trough
      queue_req(16'h4000, 1'b1, 1'b0);
      queue_req(16'hBF00, 1'b1, 1'b0);
      queue_req(16'hAAAA, 1'b1, 1'b0);
      queue_req(16'h5555, 1'b0, 1'b0);

      // Random: mostly uniform phases, some clustered on the quadrant edges.
      // Twice the sender stops until every sample is back.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 9) < 7) begin
            phase = PHASE_BITS'($urandom);
         end else begin
            phase = PHASE_BITS'(($urandom_range(0, 3) << (PHASE_BITS - 2)) +
                                $urandom_range(0, 1023) - 512);
         end
         queue_req(phase, 1'($urandom), n == 600 || n == 1500);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every item to pass and every sample to come back
      while (reqs_accepted < reqs_total || samples_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (samples_due.size() != 0)
         report_mismatch("missing sample", '0, samples_due[0]);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: ends the run as failing if the stream has not finished
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> quarter_wave_sine_table_dac_core.f
src/qwsin_pkg.sv
src/qwsin_ram.sv
src/qwsin_div.sv
src/qwsin_fill.sv
src/quarter_wave_sine_table_dac_core.sv
tb/sv/tb_quarter_wave_sine_table_dac_core.sv
